### design/dses_pkg.sv
// Package for the dual encoder speed estimator: field widths, constants,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dses_pkg;

  localparam int TIME_W        = 32;
  localparam int COUNT_FIELD_W = 32;
  localparam int SPEED_W       = 32;
  localparam int PERIOD_W      = 16;
  localparam int GAIN_W        = 17;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 17;

  localparam int MS_W        = 10;
  localparam int MS_PER_S    = 1000;
  localparam int GAIN_FRAC_W = 16;

  localparam int QUOT_W   = 33;
  localparam int CNT_W    = 6;
  localparam int DIFF_W   = 33;
  localparam int PROD_G_W = 51;
  localparam int STEP_W   = 36;
  localparam int SUM_W    = 37;

  localparam logic [GAIN_W-1:0]   GAIN_ONE     = 17'h1_0000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd33;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd1;

  localparam logic [QUOT_W-1:0] Q_POS_MAX = 33'h0_7FFF_FFFF;
  localparam logic [QUOT_W-1:0] Q_NEG_MAX = 33'h0_8000_0000;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = 32'sh8000_0000;
  localparam logic signed [SUM_W-1:0]   SUM_MAX   = 37'sh0_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0]   SUM_MIN   = -37'sh0_8000_0000;

  localparam logic [PROD_G_W-1:0] ROUND_HALF = 51'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEFT_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RIGHT_GAIN = 2'd2;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_SET    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCALE,
    ST_DIV_INIT,
    ST_DIV,
    ST_RAW,
    ST_MUL,
    ST_ROUND,
    ST_COMMIT,
    ST_OUT_UPD,
    ST_OUT
  } dses_state_t;

  typedef struct packed {
    logic load_in;
    logic set_counts;
    logic set_time;
    logic delta;
    logic scale;
    logic div_init;
    logic div_step;
    logic raw;
    logic mul;
    logic rnd;
    logic commit;
    logic out_load;
    logic out_updated;
  } dses_cmd_t;

  typedef struct packed {
    logic action;
    logic early;
    logic backwards;
    logic out_free;
  } dses_stat_t;

endpackage
`default_nettype wire

### design/dses_in_if.sv
// Input channel of the speed estimator: valid/ready plus one sample item.
// Depends on dses_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dses_in_if;
  import dses_pkg::*;

  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [TIME_W-1:0]               time_ms;
  logic signed [COUNT_FIELD_W-1:0] left_count;
  logic signed [COUNT_FIELD_W-1:0] right_count;

  modport source (output valid, output action, output time_ms, output left_count,
                  output right_count, input ready);
  modport sink (input valid, input action, input time_ms, input left_count,
                input right_count, output ready);
endinterface
`default_nettype wire

### design/dses_out_if.sv
// Result channel of the speed estimator: valid/ready plus one result item.
// Depends on dses_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dses_out_if;
  import dses_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      updated;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;

  modport source (output valid, output updated, output left_speed, output right_speed,
                  input ready);
  modport sink (input valid, input updated, input left_speed, input right_speed,
                output ready);
endinterface
`default_nettype wire

### design/dses_cfg_if.sv
// Configuration write channel of the speed estimator: valid/ready, index, data.
// Depends on dses_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dses_cfg_if;
  import dses_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### design/dual_encoder_speed_estimator_unit.sv
// Top level of the dual encoder speed estimator: channel interfaces, controller
// and datapath. Depends on dses_pkg, dses_in_if, dses_out_if, dses_cfg_if,
// dses_ctrl and dses_dp.
//
// Takes one item at a time and returns exactly one result item for it. An overwrite,
// a sample that comes too early or one whose time went backwards goes straight from
// the decision to the result; a sample that updates the speeds also passes through
// the 33-step bit-serial divider that both lanes run side by side, plus the
// scaling, rounding, smoothing multiply and accumulate stages. The next item is
// taken as soon as the result sits in the output register. Speeds are signed
// Q.SPEED_FRAC_BITS counts per second, saturated to 32 bits; configuration writes
// are always ready.
`timescale 1ns / 1ps
`default_nettype none
module dual_encoder_speed_estimator_unit #(
  parameter int COUNT_WIDTH     = 32,
  parameter int SPEED_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  dses_in_if.sink     in_ch,
  dses_out_if.source  out_ch,
  dses_cfg_if.sink    cfg_ch
);
  import dses_pkg::*;

  dses_cmd_t  cmd;
  dses_stat_t stat;
  logic       in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  dses_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dses_dp #(
    .COUNT_WIDTH     (COUNT_WIDTH),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_ch.action),
    .in_time_ms      (in_ch.time_ms),
    .in_left_count   (in_ch.left_count),
    .in_right_count  (in_ch.right_count),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_updated     (out_ch.updated),
    .out_left_speed  (out_ch.left_speed),
    .out_right_speed (out_ch.right_speed)
  );

endmodule
`default_nettype wire

### design/dses_ctrl.sv
// Controller of the speed estimator: sequences decision, scaling, division,
// smoothing and result transfer. Depends on dses_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dses_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dses_pkg::dses_stat_t  stat,
  output dses_pkg::dses_cmd_t   cmd
);
  import dses_pkg::*;

  dses_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (stat.action == ACT_SET) begin
          cmd.set_counts = 1'b1;
          state_nxt      = ST_OUT;
        end else if (stat.early) begin
          state_nxt = ST_OUT;
        end else if (stat.backwards) begin
          cmd.set_time = 1'b1;
          state_nxt    = ST_OUT;
        end else begin
          cmd.delta = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          state_nxt = ST_RAW;
        end
      end
      ST_RAW: begin
        cmd.raw   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_OUT_UPD;
      end
      ST_OUT_UPD: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_updated = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/dses_dp.sv
// Datapath of the speed estimator: configuration and state registers, two
// speed lanes with bit-serial divider, smoothing multiplier, output register.
// Depends on dses_pkg; driven by dses_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module dses_dp #(
  parameter int COUNT_WIDTH     = 32,
  parameter int SPEED_FRAC_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  dses_pkg::dses_cmd_t                       cmd,
  output dses_pkg::dses_stat_t                      stat,
  input  logic                                      in_action,
  input  logic [dses_pkg::TIME_W-1:0]               in_time_ms,
  input  logic signed [dses_pkg::COUNT_FIELD_W-1:0] in_left_count,
  input  logic signed [dses_pkg::COUNT_FIELD_W-1:0] in_right_count,
  input  logic                                      cfg_valid,
  input  logic [dses_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [dses_pkg::CFG_DATA_W-1:0]           cfg_data,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      out_updated,
  output logic signed [dses_pkg::SPEED_W-1:0]       out_left_speed,
  output logic signed [dses_pkg::SPEED_W-1:0]       out_right_speed
);
  import dses_pkg::*;

  localparam int MAG_W    = COUNT_WIDTH + 1;
  localparam int PROD_K_W = MAG_W + MS_W;
  localparam int NUM_W    = PROD_K_W + SPEED_FRAC_BITS;
  localparam int RI_W     = ((NUM_W > TIME_W - 1) ? NUM_W : TIME_W - 1) + 1;
  localparam int DIV_W    = (RI_W > QUOT_W + 1) ? RI_W : QUOT_W + 1;
  localparam int HI_W     = DIV_W - QUOT_W;
  localparam int CMP_W    = (HI_W > TIME_W) ? HI_W : TIME_W;

  logic [PERIOD_W-1:0] period_r;
  logic [GAIN_W-1:0]   gain_r [2];

  logic                          action_r;
  logic [TIME_W-1:0]             time_r;
  logic signed [COUNT_WIDTH-1:0] new_cnt_r [2];

  logic [TIME_W-1:0]             last_time_r;
  logic signed [COUNT_WIDTH-1:0] last_cnt_r [2];
  logic signed [SPEED_W-1:0]     smooth_r [2];

  logic [TIME_W-1:0]             dt_r;
  logic [MAG_W-1:0]              mag_r [2];
  logic                          neg_r [2];
  logic [NUM_W-1:0]              num_r [2];
  logic [TIME_W-1:0]             part_r [2];
  logic [QUOT_W-1:0]             quo_r [2];
  logic                          ovf_r [2];
  logic signed [SPEED_W-1:0]     raw_r [2];
  logic signed [PROD_G_W-1:0]    prod_r [2];
  logic signed [STEP_W-1:0]      step_r [2];

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_updated_r;
  logic signed [SPEED_W-1:0]     out_speed_r [2];

  logic [TIME_W-1:0]             dt_c;
  logic [PERIOD_W-1:0]           period_eff_c;
  logic signed [COUNT_WIDTH-1:0] in_cnt_c [2];
  logic signed [MAG_W-1:0]       delta_c [2];
  logic [MAG_W-1:0]              mag_c [2];
  logic [NUM_W-1:0]              num_c [2];
  logic [DIV_W-1:0]              ri_c [2];
  logic [HI_W-1:0]               hi_c [2];
  logic                          ovf_c [2];
  logic [TIME_W:0]               p2_c [2];
  logic                          ge_c [2];
  logic [TIME_W-1:0]             part_c [2];
  logic signed [SPEED_W-1:0]     raw_c [2];
  logic [GAIN_W-1:0]             gain_eff_c [2];
  logic signed [DIFF_W-1:0]      diff_c [2];
  logic signed [PROD_G_W-1:0]    prod_c [2];
  logic [PROD_G_W-1:0]           pmag_c [2];
  logic [PROD_G_W-1:0]           rsum_c [2];
  logic [STEP_W-1:0]             smag_c [2];
  logic signed [STEP_W-1:0]      step_c [2];
  logic signed [SUM_W-1:0]       acc_c [2];
  logic signed [SPEED_W-1:0]     sat_c [2];

  assign in_cnt_c[0] = in_left_count[COUNT_WIDTH-1:0];
  assign in_cnt_c[1] = in_right_count[COUNT_WIDTH-1:0];

  assign period_eff_c = (period_r == '0) ? PERIOD_MIN : period_r;
  assign dt_c         = time_r - last_time_r;

  assign stat.action    = action_r;
  assign stat.early     = dt_c < TIME_W'(period_eff_c);
  assign stat.backwards = time_r < last_time_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      delta_c[i] = MAG_W'(new_cnt_r[i]) - MAG_W'(last_cnt_r[i]);
      mag_c[i]   = delta_c[i][MAG_W-1] ? MAG_W'(-delta_c[i]) : MAG_W'(delta_c[i]);

      num_c[i] = NUM_W'(PROD_K_W'(mag_r[i]) * PROD_K_W'(MS_PER_S)) << SPEED_FRAC_BITS;

      ri_c[i]  = DIV_W'(num_r[i]) + DIV_W'(dt_r[TIME_W-1:1]);
      hi_c[i]  = ri_c[i][DIV_W-1:QUOT_W];
      ovf_c[i] = CMP_W'(hi_c[i]) >= CMP_W'(dt_r);

      p2_c[i]   = {part_r[i], quo_r[i][QUOT_W-1]};
      ge_c[i]   = p2_c[i] >= {1'b0, dt_r};
      part_c[i] = ge_c[i] ? TIME_W'(p2_c[i] - {1'b0, dt_r}) : p2_c[i][TIME_W-1:0];

      priority if (neg_r[i]) begin
        raw_c[i] = (ovf_r[i] || quo_r[i] > Q_NEG_MAX) ? SPEED_MIN : -(SPEED_W'(quo_r[i]));
      end else begin
        raw_c[i] = (ovf_r[i] || quo_r[i] > Q_POS_MAX) ? SPEED_MAX : SPEED_W'(quo_r[i]);
      end

      gain_eff_c[i] = (gain_r[i] > GAIN_ONE) ? GAIN_ONE : gain_r[i];
      diff_c[i]     = DIFF_W'(raw_r[i]) - DIFF_W'(smooth_r[i]);
      prod_c[i]     = diff_c[i] * $signed({1'b0, gain_eff_c[i]});

      pmag_c[i] = prod_r[i][PROD_G_W-1] ? PROD_G_W'(-prod_r[i]) : PROD_G_W'(prod_r[i]);
      rsum_c[i] = pmag_c[i] + ROUND_HALF;
      smag_c[i] = STEP_W'(rsum_c[i] >> GAIN_FRAC_W);
      step_c[i] = prod_r[i][PROD_G_W-1] ? -$signed(smag_c[i]) : $signed(smag_c[i]);

      acc_c[i] = SUM_W'(smooth_r[i]) + SUM_W'(step_r[i]);
      priority if (acc_c[i] > SUM_MAX) begin
        sat_c[i] = SPEED_MAX;
      end else if (acc_c[i] < SUM_MIN) begin
        sat_c[i] = SPEED_MIN;
      end else begin
        sat_c[i] = SPEED_W'(acc_c[i]);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      gain_r[0]   <= GAIN_ONE;
      gain_r[1]   <= GAIN_ONE;
      last_time_r <= '0;
      last_cnt_r[0] <= '0;
      last_cnt_r[1] <= '0;
      smooth_r[0] <= '0;
      smooth_r[1] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_IDX_PERIOD:     period_r  <= cfg_data[PERIOD_W-1:0];
          CFG_IDX_LEFT_GAIN:  gain_r[0] <= cfg_data;
          CFG_IDX_RIGHT_GAIN: gain_r[1] <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.set_time || cmd.commit) begin
        last_time_r <= time_r;
      end
      for (int i = 0; i < 2; i++) begin
        if (cmd.set_counts || cmd.commit) begin
          last_cnt_r[i] <= new_cnt_r[i];
        end
        if (cmd.commit) begin
          smooth_r[i] <= sat_c[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r <= in_action;
      time_r   <= in_time_ms;
    end
    if (cmd.delta) begin
      dt_r <= dt_c;
    end
    if (cmd.out_load) begin
      out_updated_r <= cmd.out_updated;
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd.load_in) begin
        new_cnt_r[i] <= in_cnt_c[i];
      end
      if (cmd.delta) begin
        mag_r[i] <= mag_c[i];
        neg_r[i] <= delta_c[i][MAG_W-1];
      end
      if (cmd.scale) begin
        num_r[i] <= num_c[i];
      end
      if (cmd.div_init) begin
        part_r[i] <= TIME_W'(hi_c[i]);
        quo_r[i]  <= ri_c[i][QUOT_W-1:0];
        ovf_r[i]  <= ovf_c[i];
      end else if (cmd.div_step) begin
        part_r[i] <= part_c[i];
        quo_r[i]  <= {quo_r[i][QUOT_W-2:0], ge_c[i]};
      end
      if (cmd.raw) begin
        raw_r[i] <= raw_c[i];
      end
      if (cmd.mul) begin
        prod_r[i] <= prod_c[i];
      end
      if (cmd.rnd) begin
        step_r[i] <= step_c[i];
      end
      if (cmd.out_load) begin
        out_speed_r[i] <= smooth_r[i];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_updated     = out_updated_r;
  assign out_left_speed  = out_speed_r[0];
  assign out_right_speed = out_speed_r[1];

endmodule
`default_nettype wire

### dv/tb_dual_encoder_speed_estimator_unit.sv
// Testbench for dual_encoder_speed_estimator_unit: random and directed position samples,
// a clocked driver and monitor, and an in-bench speed predictor checked per result.
// Depends on dses_pkg, dses_in_if, dses_out_if, dses_cfg_if and the RTL top level.
`timescale 1ns / 1ps
module tb_dual_encoder_speed_estimator_unit;
  import dses_pkg::*;

  localparam int COUNT_BITS = 32;
  localparam int FRAC_BITS  = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam logic signed [COUNT_FIELD_W-1:0] COUNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COUNT_FIELD_W-1:0] COUNT_MIN = 32'sh8000_0000;

  typedef struct {
    logic                            action;
    logic [TIME_W-1:0]               time_ms;
    logic signed [COUNT_FIELD_W-1:0] left_count;
    logic signed [COUNT_FIELD_W-1:0] right_count;
  } sample_item_t;

  typedef struct {
    logic                      updated;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
  } speed_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dses_in_if  in_ch ();
  dses_out_if out_ch ();
  dses_cfg_if cfg_ch ();

  dual_encoder_speed_estimator_unit #(
    .COUNT_WIDTH(COUNT_BITS),
    .SPEED_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  logic [PERIOD_W-1:0] period_reg = PERIOD_RESET;
  logic [GAIN_W-1:0]   left_gain_reg = GAIN_ONE;
  logic [GAIN_W-1:0]   right_gain_reg = GAIN_ONE;
  logic [TIME_W-1:0]   last_time = '0;
  longint              left_pos = 0;
  longint              right_pos = 0;
  longint              left_spd = 0;
  longint              right_spd = 0;

  sample_item_t  pending_samples[$];
  speed_result_t expected_speeds[$];
  sample_item_t  driven_sample;
  speed_result_t want;

  int unsigned send_gap_max = 10;
  int unsigned recv_gap_max = 10;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_cycles = 0;
  int unsigned samples_queued = 0;
  int unsigned samples_sent = 0;
  int unsigned results_seen = 0;
  int unsigned update_count = 0;
  int unsigned mismatches = 0;

  logic [TIME_W-1:0]               gen_time = '0;
  logic signed [COUNT_FIELD_W-1:0] gen_left = '0;
  logic signed [COUNT_FIELD_W-1:0] gen_right = '0;

  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_s32(longint v);
    if (v > longint'(SPEED_MAX)) return longint'(SPEED_MAX);
    if (v < longint'(SPEED_MIN)) return longint'(SPEED_MIN);
    return v;
  endfunction

  function automatic longint raw_speed(longint delta, logic [TIME_W-1:0] span);
    longint den;
    den = span;
    return clamp_s32(round_div(delta * MS_PER_S * (longint'(1) <<< FRAC_BITS), den));
  endfunction

  function automatic longint smooth_speed(longint cur, longint raw, logic [GAIN_W-1:0] gain);
    longint g;
    g = (gain > GAIN_ONE) ? GAIN_ONE : gain;
    return clamp_s32(cur + round_div((raw - cur) * g, longint'(GAIN_ONE)));
  endfunction

  function automatic speed_result_t estimate_speeds(sample_item_t s);
    speed_result_t r;
    logic [TIME_W-1:0] elapsed;
    logic [PERIOD_W-1:0] min_gap;
    longint left_raw, right_raw;
    r.updated = 1'b0;
    if (s.action == ACT_SET) begin
      left_pos = s.left_count;
      right_pos = s.right_count;
    end else begin
      elapsed = s.time_ms - last_time;
      min_gap = (period_reg == '0) ? PERIOD_MIN : period_reg;
      if (elapsed >= min_gap) begin
        if (s.time_ms < last_time) begin
          last_time = s.time_ms;
        end else begin
          left_raw = raw_speed(longint'(s.left_count) - left_pos, elapsed);
          right_raw = raw_speed(longint'(s.right_count) - right_pos, elapsed);
          left_spd = smooth_speed(left_spd, left_raw, left_gain_reg);
          right_spd = smooth_speed(right_spd, right_raw, right_gain_reg);
          left_pos = s.left_count;
          right_pos = s.right_count;
          last_time = s.time_ms;
          r.updated = 1'b1;
        end
      end
    end
    r.left_speed = left_spd[SPEED_W-1:0];
    r.right_speed = right_spd[SPEED_W-1:0];
    return r;
  endfunction

  // Sender: hold the item until transfer, then wait the drawn gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_speeds.push_back(estimate_speeds(driven_sample));
        samples_sent++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          driven_sample = pending_samples.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.action <= driven_sample.action;
          in_ch.time_ms <= driven_sample.time_ms;
          in_ch.left_count <= driven_sample.left_count;
          in_ch.right_count <= driven_sample.right_count;
          send_wait = $urandom_range(0, send_gap_max);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer, then stall for the drawn gap or a long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_speeds.size() == 0) begin
          $error("result with nothing expected: updated %0d left %0d right %0d",
                 out_ch.updated, out_ch.left_speed, out_ch.right_speed);
          mismatches++;
        end else begin
          want = expected_speeds.pop_front();
          if (want.updated) update_count++;
          if (out_ch.updated !== want.updated) begin
            $error("updated: expected %0d, got %0d", want.updated, out_ch.updated);
            mismatches++;
          end
          if (out_ch.left_speed !== want.left_speed) begin
            $error("left_speed: expected %0d, got %0d", want.left_speed, out_ch.left_speed);
            mismatches++;
          end
          if (out_ch.right_speed !== want.right_speed) begin
            $error("right_speed: expected %0d, got %0d", want.right_speed,
                   out_ch.right_speed);
            mismatches++;
          end
        end
        if (results_seen == 450 || results_seen == 1150) hold_cycles = 400;
        else recv_wait = $urandom_range(0, recv_gap_max);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_sample(input logic act, input logic [TIME_W-1:0] t,
                              input logic signed [COUNT_FIELD_W-1:0] l,
                              input logic signed [COUNT_FIELD_W-1:0] r);
    sample_item_t s;
    s.action = act;
    s.time_ms = t;
    s.left_count = l;
    s.right_count = r;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  function automatic logic [COUNT_FIELD_W-1:0] random_step();
    int unsigned k;
    logic [COUNT_FIELD_W-1:0] mag;
    k = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12) : $urandom_range(13, 31);
    mag = $urandom & ((32'h1 << k) - 32'h1);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic queue_random_samples(input int unsigned count);
    int unsigned per, pick;
    logic [TIME_W-1:0] step;
    repeat (count) begin
      per = (period_reg == '0) ? 1 : period_reg;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        if ($urandom_range(0, 1)) begin
          gen_left = $urandom;
          gen_right = $urandom;
        end else begin
          gen_left += random_step();
          gen_right += random_step();
        end
        queue_sample(ACT_SET, $urandom, gen_left, gen_right);
      end else begin
        if (pick < 20) step = $urandom_range(0, per - 1);
        else if (pick < 88) step = per + $urandom_range(0, per);
        else if (pick < 94) step = $urandom;
        else step = -($urandom_range(1, 4000));
        gen_time += step;
        if ($urandom_range(0, 49) == 0) begin
          gen_left = $urandom;
          gen_right = $urandom;
        end else begin
          gen_left += random_step();
          gen_right += random_step();
        end
        queue_sample(ACT_SAMPLE, gen_time, gen_left, gen_right);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_IDX_PERIOD:     period_reg = val[PERIOD_W-1:0];
      CFG_IDX_LEFT_GAIN:  left_gain_reg = val;
      CFG_IDX_RIGHT_GAIN: right_gain_reg = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (results_seen < samples_queued)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_SAMPLE;
    in_ch.time_ms = '0;
    in_ch.left_count = '0;
    in_ch.right_count = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_IDX_PERIOD;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    queue_sample(ACT_SAMPLE, 32'd0, 32'sd0, 32'sd0);
    queue_sample(ACT_SET, 32'd0, 32'sd100, -32'sd100);
    queue_sample(ACT_SAMPLE, 32'd33, 32'sd1100, -32'sd1300);
    queue_sample(ACT_SAMPLE, 32'd65, 32'sd5000, 32'sd5000);
    queue_sample(ACT_SAMPLE, 32'd10, 32'sd0, 32'sd0);
    queue_sample(ACT_SAMPLE, 32'd42, 32'sd0, 32'sd0);
    queue_sample(ACT_SET, 32'hFFFF_FFFF, COUNT_MIN, COUNT_MAX);
    queue_sample(ACT_SAMPLE, 32'd43, COUNT_MAX, COUNT_MIN);
    queue_sample(ACT_SAMPLE, 32'd76, COUNT_MIN, COUNT_MAX);
    queue_sample(ACT_SAMPLE, 32'hFFFF_FFFF, -32'sd1, 32'sd1);
    queue_sample(ACT_SAMPLE, 32'd5, 32'sd7, -32'sd7);
    queue_sample(ACT_SAMPLE, 32'd64, 32'sd0, 32'sd0);
    queue_sample(ACT_SAMPLE, 32'd97, 32'sd3, -32'sd3);
    queue_sample(ACT_SAMPLE, 32'd512097, 32'sd4, -32'sd4);
    queue_sample(ACT_SET, 32'h5555_AAAA, 32'sh2AAA_5555, 32'shD555_AAAA);
    queue_sample(ACT_SAMPLE, 32'hAAAA_5555, 32'sh5555_AAAA, -32'sh5555_AAAA);
    settle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          write_reg(CFG_IDX_PERIOD, 17'd1);
          write_reg(CFG_IDX_LEFT_GAIN, GAIN_ONE);
          write_reg(CFG_IDX_RIGHT_GAIN, GAIN_ONE);
        end
        1: begin
          write_reg(CFG_IDX_PERIOD, 17'd0);
          write_reg(CFG_IDX_LEFT_GAIN, 17'd0);
          write_reg(CFG_IDX_RIGHT_GAIN, 17'h1_FFFF);
        end
        2: begin
          write_reg(CFG_IDX_PERIOD, 17'd65535);
          write_reg(CFG_IDX_LEFT_GAIN, CFG_DATA_W'($urandom_range(0, 131071)));
          write_reg(CFG_IDX_RIGHT_GAIN, CFG_DATA_W'($urandom_range(0, 131071)));
        end
        3: begin
          write_reg(CFG_IDX_PERIOD, CFG_DATA_W'($urandom_range(1, 60)));
          write_reg(CFG_IDX_LEFT_GAIN, 17'd32768);
          write_reg(CFG_IDX_RIGHT_GAIN, 17'h1_0001);
        end
        4: begin
          write_reg(CFG_IDX_PERIOD, 17'd2);
          write_reg(CFG_IDX_LEFT_GAIN, 17'd1);
          write_reg(CFG_IDX_RIGHT_GAIN, 17'd65535);
        end
        5: begin
          write_reg(CFG_IDX_PERIOD, 17'h1_0005);
          write_reg(CFG_IDX_UNUSED, 17'h1_FFFF);
          write_reg(CFG_IDX_LEFT_GAIN, 17'h1_5555);
          write_reg(CFG_IDX_RIGHT_GAIN, 17'h0_AAAA);
        end
        default: begin
          write_reg(CFG_IDX_PERIOD, CFG_DATA_W'($urandom_range(1, 200)));
          write_reg(CFG_IDX_LEFT_GAIN, CFG_DATA_W'($urandom_range(0, 131071)));
          write_reg(CFG_IDX_RIGHT_GAIN, CFG_DATA_W'($urandom_range(0, 131071)));
        end
      endcase
      if (p == 7) gen_time = 32'hFFFF_F000;
      send_gap_max = (p % 4 == 1 || p % 4 == 3) ? 0 : 10;
      recv_gap_max = (p % 4 == 1 || p % 4 == 2) ? 0 : 10;
      queue_random_samples(133);
      settle();
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d samples over 10 register settings, %0d results checked",
             samples_sent, results_seen);
    $display("%0d results carried a new speed estimate, %0d mismatches",
             update_count, mismatches);
    if (mismatches == 0 && expected_speeds.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
